### design/mstseq_pkg.sv
// ---------------------------------------------------------------------------
// mstseq_pkg: shared types and constants for the melody tone sequencer
// Note half-period ROM, counter widths and configuration register map.
// ---------------------------------------------------------------------------
`default_nettype none

package mstseq_pkg;

    // widths of the sequencer state
    localparam int HALF_W   = 16;
    localparam int ELAPSED_W = 24;
    localparam int NOTE_W   = 4;
    localparam int ROM_DEPTH = 16;

    // number of notes played before the index wraps (1 to 16)
    localparam logic [NOTE_W:0] NoteCount = 5'd12;

    // configuration register map
    localparam int ADDR_W = 3;
    localparam logic [0:0] RegNoteDuration = 1'b0;
    localparam logic [ELAPSED_W-1:0] DurationReset = 24'd200000;

    typedef logic [HALF_W-1:0]    t_half;
    typedef logic [ELAPSED_W-1:0] t_elapsed;
    typedef logic [NOTE_W-1:0]    t_note;

    // half periods in microseconds, 500000 / frequency, unused entries zero
    localparam t_half HalfPeriodRom [ROM_DEPTH] = '{
        16'd568, 16'd478, 16'd379, 16'd637, 16'd425, 16'd506, 16'd337, 16'd757,
        16'd239, 16'd284, 16'd850, 16'd318, 16'd0,   16'd0,   16'd0,   16'd0
    };

endpackage

`default_nettype wire

### design/melody_square_tone_sequencer.sv
// A request's result becomes valid after it passes the input register and then
// the sequencer update into the result register.
// One request per clock while the result register is not stalled; the sequencer state updates with each tick.
// Reset (synchronous, active low) clears the note index, tone state, counters
// and pipeline valids, and loads the note duration register with 200000.
// ---------------------------------------------------------------------------
// melody_square_tone_sequencer: square-wave melody player
// Each request is one microsecond tick with an enable; the block toggles the
// buzzer level at each note's half period and steps through a fixed melody.
// ---------------------------------------------------------------------------
`default_nettype none

module melody_square_tone_sequencer
    import mstseq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,

    // tick requests
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_play_enable,

    // results
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_buzzer_level,
    output logic                   o_note_started,
    output logic [NOTE_W-1:0]      o_note_number,

    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic     duration_sel;
    t_elapsed r_note_duration;

    logic     r_in_valid;
    logic     r_in_enable;
    logic     advance;

    t_note    r_next_note;
    logic     r_tone_active;
    logic     r_pin_level;
    t_half    r_cur_half;
    t_half    r_half_cnt;
    t_elapsed r_elapsed;

    t_note    n_next_note;
    logic     n_tone_active;
    logic     n_pin_level;
    t_half    n_cur_half;
    t_half    n_half_cnt;
    t_elapsed n_elapsed;
    logic     n_started;

    logic     r_out_valid;

    // configuration register
    assign pready = 1'b1;
    assign duration_sel = (paddr[ADDR_W-1] == RegNoteDuration);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note_duration <= DurationReset;
        end else if (psel && penable && pwrite && pready && duration_sel) begin
            r_note_duration <= pwdata[ELAPSED_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (duration_sel) begin
            prdata = {{(32-ELAPSED_W){1'b0}}, r_note_duration};
        end
    end

    // pipeline flow: the update stage moves when the result register is free
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_enable <= i_play_enable;
        end
    end

    // sequencer update for one tick
    always_comb begin
        t_half    half_inc;
        t_elapsed elapsed_inc;
        logic     active;

        n_next_note   = r_next_note;
        n_tone_active = r_tone_active;
        n_pin_level   = r_pin_level;
        n_cur_half    = r_cur_half;
        n_half_cnt    = r_half_cnt;
        n_elapsed     = r_elapsed;
        n_started     = 1'b0;
        active        = r_tone_active;

        half_inc    = (r_half_cnt == {HALF_W{1'b1}}) ? r_half_cnt : r_half_cnt + 1'b1;
        elapsed_inc = (r_elapsed == {ELAPSED_W{1'b1}}) ? r_elapsed : r_elapsed + 1'b1;

        if (r_in_enable) begin
            // running note: count, toggle at half period, end after duration
            if (r_tone_active) begin
                n_half_cnt = half_inc;
                n_elapsed  = elapsed_inc;
                if (half_inc >= r_cur_half) begin
                    n_pin_level = !r_pin_level;
                    n_half_cnt  = '0;
                end
                if (elapsed_inc >= r_note_duration) begin
                    active      = 1'b0;
                    n_pin_level = 1'b0;
                end
            end
            // idle: load the next note and advance the index
            if (!active) begin
                n_cur_half = HalfPeriodRom[r_next_note];
                n_half_cnt = '0;
                n_elapsed  = '0;
                n_started  = 1'b1;
                active     = 1'b1;
                if ({1'b0, r_next_note} + 1'b1 >= NoteCount) begin
                    n_next_note = '0;
                end else begin
                    n_next_note = r_next_note + 1'b1;
                end
            end
            n_tone_active = active;
        end
    end

    // sequencer state, updated as each tick moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_note   <= '0;
            r_tone_active <= 1'b0;
            r_pin_level   <= 1'b0;
            r_cur_half    <= '0;
            r_half_cnt    <= '0;
            r_elapsed     <= '0;
        end else if (advance && r_in_valid) begin
            r_next_note   <= n_next_note;
            r_tone_active <= n_tone_active;
            r_pin_level   <= n_pin_level;
            r_cur_half    <= n_cur_half;
            r_half_cnt    <= n_half_cnt;
            r_elapsed     <= n_elapsed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            o_buzzer_level <= n_pin_level;
            o_note_started <= n_started;
            o_note_number  <= n_next_note;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    // the pin is only high while a note is playing
    a_pin_low_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tone_active |-> !r_pin_level)
        else $error("buzzer high with no active tone");

    // the note index never reaches the note count
    a_note_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_next_note} < NoteCount)
        else $error("note index out of range");

    // a reported note start leaves a tone active
    a_start_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && n_started) |=> r_tone_active)
        else $error("note start without active tone");
`endif

endmodule

`default_nettype wire
